>>> design/f2l_pkg.sv
// Shared types and constants for the float to 64-bit integer converter.
// No dependencies; the core and its checker reference it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package f2l_pkg;

   // Source format selector carried on the request side
   localparam logic FMT_SINGLE = 1'b0;
   localparam logic FMT_DOUBLE = 1'b1;

   // Classification reported with every result
   typedef enum logic [1:0] {
      CASE_IN_RANGE  = 2'd0,
      CASE_BELOW_ONE = 2'd1,
      CASE_SATURATED = 2'd2,
      CASE_NAN       = 2'd3
   } case_code_type;

   localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

   // Exponent constants, widened to the double exponent width
   localparam logic [10:0] SGL_BIAS    = 11'h07F;
   localparam logic [10:0] SGL_EXP_MAX = 11'h0FF;
   localparam logic [10:0] DBL_BIAS    = 11'h3FF;
   localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
   localparam logic [10:0] MAX_EXP_UNB = 11'd63;

   // Decode stage payload
   typedef struct packed {
      case_code_type code;
      logic          neg;
      logic [5:0]    shift;
      logic [63:0]   mant;
   } dec_type;

   // Shift stage payload
   typedef struct packed {
      case_code_type code;
      logic          neg;
      logic [63:0]   mag;
   } shf_type;

endpackage

`default_nettype wire

>>> design/float_to_long_truncate_core.sv
// Top level of the float to signed 64-bit integer converter (truncating, saturating).
// Depends on f2l_pkg for the case codes, constants and stage payload types.
// A request transfer passes the decode, shift and result registers to reach rsp_*.
// Throughput: one conversion per cycle when not stalled; decode, barrel shift and
//   negate/select each own one register stage and the three stages advance together.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module float_to_long_truncate_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] bits
   input  wire logic        req_tuser,   // [0] func (0 single, 1 double)
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [63:0] result (signed)
   output      logic [1:0]  rsp_tuser    // [1:0] case_code
);

   // Pipeline advance: the whole pipe moves when the output register is empty
   // or its transfer completes this cycle; otherwise every stage holds.
   logic advance;

   logic             s1_valid_ff, s1_valid_in;
   f2l_pkg::dec_type s1_ff, s1_in;
   logic             s2_valid_ff, s2_valid_in;
   f2l_pkg::shf_type s2_ff, s2_in;
   logic             s3_valid_ff, s3_valid_in;
   logic [63:0]      result_ff, result_in;
   logic [1:0]       code_ff, code_in;

   assign advance    = !s3_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------
   // Stage 1: unpack the selected format and classify the exponent
   // ---------------------------------------------------------------
   logic        is_double;
   logic        dec_neg;
   logic [10:0] dec_exp;
   logic [10:0] dec_bias;
   logic [10:0] dec_exp_max;
   logic [10:0] dec_sat_lim;
   logic        dec_frac_nz;
   logic [63:0] dec_mant;
   logic [10:0] dec_shift_wide;

   always_comb begin
      is_double = (req_tuser == f2l_pkg::FMT_DOUBLE);
      if (is_double) begin
         dec_neg     = req_tdata[63];
         dec_exp     = req_tdata[62:52];
         dec_frac_nz = |req_tdata[51:0];
         dec_mant    = {1'b1, req_tdata[51:0], 11'b0};
         dec_bias    = f2l_pkg::DBL_BIAS;
         dec_exp_max = f2l_pkg::DBL_EXP_MAX;
      end else begin
         // upper half of the pattern is ignored in single mode
         dec_neg     = req_tdata[31];
         dec_exp     = {3'b000, req_tdata[30:23]};
         dec_frac_nz = |req_tdata[22:0];
         dec_mant    = {1'b1, req_tdata[22:0], 40'b0};
         dec_bias    = f2l_pkg::SGL_BIAS;
         dec_exp_max = f2l_pkg::SGL_EXP_MAX;
      end
      // first biased exponent whose magnitude no longer fits
      dec_sat_lim    = dec_bias + f2l_pkg::MAX_EXP_UNB;
      // right shift that drops the hidden one to its integer weight (1..63)
      dec_shift_wide = dec_sat_lim - dec_exp;
   end

   always_comb begin
      s1_in.neg   = dec_neg;
      s1_in.mant  = dec_mant;
      s1_in.shift = dec_shift_wide[5:0];
      if (dec_exp == dec_exp_max) begin
         s1_in.code = dec_frac_nz ? f2l_pkg::CASE_NAN : f2l_pkg::CASE_SATURATED;
      end else if (dec_exp < dec_bias) begin
         s1_in.code = f2l_pkg::CASE_BELOW_ONE;
      end else if (dec_exp >= dec_sat_lim) begin
         s1_in.code = f2l_pkg::CASE_SATURATED;
      end else begin
         s1_in.code = f2l_pkg::CASE_IN_RANGE;
      end
      s1_valid_in = req_tvalid;
   end

   // ---------------------------------------------------------------
   // Stage 2: barrel shift right, truncating toward zero
   // ---------------------------------------------------------------
   always_comb begin
      s2_in.code  = s1_ff.code;
      s2_in.neg   = s1_ff.neg;
      s2_in.mag   = s1_ff.mant >> s1_ff.shift;
      s2_valid_in = s1_valid_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: apply sign, saturate or zero by class
   // ---------------------------------------------------------------
   always_comb begin
      case (s2_ff.code)
         f2l_pkg::CASE_IN_RANGE: begin
            result_in = s2_ff.neg ? (64'd0 - s2_ff.mag) : s2_ff.mag;
         end
         f2l_pkg::CASE_SATURATED: begin
            result_in = s2_ff.neg ? f2l_pkg::SAT_NEG : f2l_pkg::SAT_POS;
         end
         default: begin
            // below one and NaN both give zero
            result_in = 64'd0;
         end
      endcase
      code_in     = s2_ff.code;
      s3_valid_in = s2_valid_ff;
   end

   // Valid bits: cleared by reset, advance as one
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload: no reset, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         result_ff <= result_in;
         code_ff   <= code_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = result_ff;
   assign rsp_tuser  = code_ff;

endmodule

`default_nettype wire

>>> design/f2l_checker.sv
// Port-level checker for the float to integer converter, bound to the top level.
// Depends on f2l_pkg for case codes and saturation constants.
`timescale 1ns / 1ps
`default_nettype none

module f2l_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // requests are taken exactly when the output side can advance
   a_ready_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not track result backpressure");

   // NaN and below-one results are zero
   a_zero_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == f2l_pkg::CASE_NAN || rsp_tuser == f2l_pkg::CASE_BELOW_ONE)
      |-> rsp_tdata == 64'd0)
      else $error("non-zero result for NaN or below-one case");

   // saturated results are one of the two limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == f2l_pkg::CASE_SATURATED
      |-> rsp_tdata == f2l_pkg::SAT_POS || rsp_tdata == f2l_pkg::SAT_NEG)
      else $error("saturated result is not a 64-bit limit");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind float_to_long_truncate_core f2l_checker u_f2l_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for float_to_long_truncate_core: single and double
// patterns are converted and checked against an in-bench truncating predictor.
// Depends on f2l_pkg for the format selector, case codes and exponent constants.
`timescale 1ns / 1ps

module tb_top;

   localparam int PIPE_LATENCY   = 3;
   localparam int HOLD_OFF_TICKS = 48;    // long receiver stall for the pressure test
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int MAX_REPORTS    = 10;

   // One expected conversion: integer value plus its class
   typedef struct {
      logic [63:0]            value;
      f2l_pkg::case_code_type code;
   } conversion_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [63:0] bits
   logic        req_tuser;   // [0] func (0 single, 1 double)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] result (signed)
   logic [1:0]  rsp_tuser;   // [1:0] case_code

   conversion_type expected_conversions[$];
   int             mismatch_count;
   int             idle_ticks;
   bit             idling_on;
   bit             hold_off_request;

   float_to_long_truncate_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the Java-style truncating conversion of one pattern.
   function automatic conversion_type convert_truncate(input logic fmt,
                                                       input logic [63:0] pattern);
      conversion_type res;
      logic        neg;
      logic        frac_nz;
      logic [10:0] expo;
      logic [10:0] bias;
      logic [10:0] expo_max;
      logic [10:0] unbiased;
      logic [63:0] mant;
      logic [63:0] mag;
      if (fmt == f2l_pkg::FMT_DOUBLE) begin
         neg      = pattern[63];
         expo     = pattern[62:52];
         frac_nz  = |pattern[51:0];
         mant     = {1'b1, pattern[51:0], 11'b0};
         bias     = f2l_pkg::DBL_BIAS;
         expo_max = f2l_pkg::DBL_EXP_MAX;
      end else begin
         // upper half of the bus means nothing in single mode
         neg      = pattern[31];
         expo     = {3'b000, pattern[30:23]};
         frac_nz  = |pattern[22:0];
         mant     = {1'b1, pattern[22:0], 40'b0};
         bias     = f2l_pkg::SGL_BIAS;
         expo_max = f2l_pkg::SGL_EXP_MAX;
      end
      if (expo == expo_max) begin
         // all-ones exponent: NaN with a fraction, infinity without
         res.value = frac_nz ? 64'd0 : (neg ? f2l_pkg::SAT_NEG : f2l_pkg::SAT_POS);
         res.code  = frac_nz ? f2l_pkg::CASE_NAN : f2l_pkg::CASE_SATURATED;
      end else if (expo < bias) begin
         res.value = 64'd0;
         res.code  = f2l_pkg::CASE_BELOW_ONE;
      end else begin
         unbiased = expo - bias;
         if (unbiased >= f2l_pkg::MAX_EXP_UNB) begin
            // 2^63 and above clip by sign, exactly -2^63 included
            res.value = neg ? f2l_pkg::SAT_NEG : f2l_pkg::SAT_POS;
            res.code  = f2l_pkg::CASE_SATURATED;
         end else begin
            mag       = mant >> (f2l_pkg::MAX_EXP_UNB - unbiased);
            res.value = neg ? (64'd0 - mag) : mag;
            res.code  = f2l_pkg::CASE_IN_RANGE;
         end
      end
      return res;
   endfunction

   // Build a random pattern; most exponents land near the in-range window.
   function automatic logic [63:0] random_pattern(input logic fmt);
      logic [63:0] raw;
      logic [10:0] expo;
      int unsigned pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 11);
      if (fmt == f2l_pkg::FMT_DOUBLE) begin
         if (pick < 7)
            expo = f2l_pkg::DBL_BIAS - 11'd2 + 11'($urandom_range(0, 67));
         else if (pick == 7) expo = f2l_pkg::DBL_EXP_MAX;
         else if (pick == 8) expo = 11'($urandom_range(0, 2));
         else                expo = raw[62:52];
         raw[62:52] = expo;
         if (pick == 7 && $urandom_range(0, 1) == 0) raw[51:0] = '0;
      end else begin
         if (pick < 7)
            expo = f2l_pkg::SGL_BIAS - 11'd2 + 11'($urandom_range(0, 67));
         else if (pick == 7) expo = f2l_pkg::SGL_EXP_MAX;
         else if (pick == 8) expo = 11'($urandom_range(0, 2));
         else                expo = {3'b000, raw[30:23]};
         raw[30:23] = expo[7:0];
         if (pick == 7 && $urandom_range(0, 1) == 0) raw[22:0] = '0;
      end
      return raw;
   endfunction

   // Offer one conversion, hold it until the transfer, then record its expected result.
   task automatic send_conversion(input logic fmt, input logic [63:0] pattern);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fmt;
      req_tdata  <= pattern;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_conversions.push_back(convert_truncate(fmt, pattern));
   endtask

   task automatic test_single_corners();
      logic [63:0] corners[] = '{
         64'h0000_0000_0000_0000,   // +0
         64'h0000_0000_8000_0000,   // -0
         64'h0000_0000_007F_FFFF,   // largest subnormal
         64'h0000_0000_BF7F_FFFF,   // just above -1.0
         64'h0000_0000_3F80_0000,   // 1.0
         64'h0000_0000_BFB0_0000,   // -1.375
         64'h0000_0000_5EFF_FFFF,   // largest value below 2^63
         64'h0000_0000_5F00_0000,   // 2^63
         64'h0000_0000_DF00_0000,   // -2^63
         64'h0000_0000_7F80_0000,   // +inf
         64'h0000_0000_FF80_0000,   // -inf
         64'h0000_0000_7FC0_0000,   // quiet NaN
         64'h0000_0000_FF80_0001,   // negative signalling NaN
         64'hFFFF_FFFF_3F80_0000    // junk in the ignored upper half
      };
      foreach (corners[i]) send_conversion(f2l_pkg::FMT_SINGLE, corners[i]);
   endtask

   task automatic test_double_corners();
      logic [63:0] corners[] = '{
         64'h0000_0000_0000_0001,   // smallest subnormal
         64'h8000_0000_0000_0000,   // -0
         64'h3FEF_FFFF_FFFF_FFFF,   // just under 1.0
         64'h3FF0_0000_0000_0000,   // 1.0
         64'hC330_0000_0000_0001,   // -(2^52 + 1)
         64'h43DF_FFFF_FFFF_FFFF,   // largest value below 2^63
         64'h43E0_0000_0000_0000,   // 2^63
         64'hC3E0_0000_0000_0000,   // -2^63
         64'h7FF0_0000_0000_0000,   // +inf
         64'hFFF0_0000_0000_0000,   // -inf
         64'hFFF0_0000_0000_0001,   // negative signalling NaN
         64'hFFFF_FFFF_FFFF_FFFF    // all ones, a NaN
      };
      foreach (corners[i]) send_conversion(f2l_pkg::FMT_DOUBLE, corners[i]);
   endtask

   task automatic test_random_mix(input int count);
      logic fmt;
      repeat (count) begin
         fmt = 1'($urandom_range(0, 1));
         send_conversion(fmt, random_pattern(fmt));
      end
   endtask

   // Stall the receiver for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_off_request = 1'b1;
      test_random_mix(40);
   endtask

   // Stimulus sequence
   initial begin : stimulus
      int drain;
      mismatch_count   = 0;
      idling_on        = 1'b1;
      hold_off_request = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= f2l_pkg::FMT_SINGLE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_corners();
      test_double_corners();
      test_random_mix(700);
      test_backpressure();
      // last stretch runs at full rate on both sides
      idling_on = 1'b0;
      test_random_mix(250);

      req_tvalid <= 1'b0;
      drain = 0;
      while (expected_conversions.size() != 0 && drain < WATCHDOG_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      if (mismatch_count == 0 && expected_conversions.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Result side ready: random short stalls, plus the long hold-off on request.
   initial begin : receiver
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_TICKS) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each result transfer against the oldest pending conversion.
   always @(posedge clock) begin
      conversion_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_conversions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result %h case %0d", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_conversions.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser !== want.code) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: result exp %h got %h, case exp %0d got %0d",
                           want.value, rsp_tdata, want.code, rsp_tuser);
            end
         end
      end
   end

   // Stop a hung run: count cycles in which neither side moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_ticks <= 0;
      end else if (idle_ticks >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_ticks <= idle_ticks + 1;
      end
   end

endmodule

>>> files.f
design/f2l_pkg.sv
design/float_to_long_truncate_core.sv
design/f2l_checker.sv
bench/tb_top.sv
